// ===== design/tensor_pad_4d_defines.svh =====
// Assertion macros used by the block's top-level file.
`ifndef TENSOR_PAD_4D_DEFINES_SVH
`define TENSOR_PAD_4D_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TPAD4_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TPAD4_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== design/tpad4_pkg.sv =====
`timescale 1ns / 1ps

package tpad4_pkg;

	localparam int RANK        = 4;
	localparam int DIM_W       = 16;
	localparam int REL_W       = DIM_W + 2;
	localparam int VALUE_W     = 32;
	localparam int ADDR_W      = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = RANK * DIM_W;
	localparam int MODE_W      = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_IN_SHAPE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_SHAPE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_BEGINS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_CONSTANT = 3'd4;

	localparam logic [MODE_W-1:0] MODE_CONST   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REFLECT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EDGE    = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EMIT = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_FETCH,
		OP_FILL
	} op_t;

	typedef struct packed {
		logic               req_type;
		logic [ADDR_W-1:0]  load_addr;
		logic [VALUE_W-1:0] load_value;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] out_value;
		logic               out_is_pad;
		logic               out_last;
	} rsp_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] in_shape;
		logic [CFG_DATA_W-1:0] out_shape;
		logic [CFG_DATA_W-1:0] pad_begins;
		logic [MODE_W-1:0]     pad_mode;
		logic [VALUE_W-1:0]    pad_constant;
	} cfg_t;

	typedef struct packed {
		op_t                        op;
		logic                       is_pad;
		logic                       last;
		logic [ADDR_W-1:0]          addr;
		logic [VALUE_W-1:0]         value;
		logic [RANK-1:0][DIM_W-1:0] idx;
	} qent_t;

	// axis 0 sits in the top lane
	function automatic logic [DIM_W-1:0] lane(input logic [CFG_DATA_W-1:0] vec,
		input int unsigned axis);
		return vec[(RANK - 1 - axis) * DIM_W +: DIM_W];
	endfunction

endpackage

// ===== design/tpad4_ram.sv =====
`timescale 1ns / 1ps

module tpad4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/tpad4_queue.sv =====
`timescale 1ns / 1ps

module tpad4_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tpad4_pkg::qent_t  push_data,
	output logic              full,
	input  logic              pop,
	output tpad4_pkg::qent_t  head,
	output logic              empty
);
	import tpad4_pkg::*;

	qent_t             slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

endmodule

// ===== design/tpad4_front.sv =====
`timescale 1ns / 1ps

module tpad4_front (
	input  logic              clk,
	input  logic              arst_n,
	input  tpad4_pkg::cfg_t   cfg,
	input  logic              coord_clr,
	input  logic              req_valid,
	output logic              req_stall,
	input  tpad4_pkg::req_t   req_data,
	output logic              q_push,
	output tpad4_pkg::qent_t  q_data,
	input  logic              q_full
);
	import tpad4_pkg::*;

	localparam logic signed [REL_W-1:0] ONE = REL_W'(1);
	localparam logic signed [REL_W-1:0] TWO = REL_W'(2);

	logic [DIM_W-1:0]        coord_q  [RANK];
	logic [DIM_W-1:0]        coord_nx [RANK];
	logic signed [REL_W-1:0] dimx     [RANK];
	logic signed [REL_W-1:0] rel      [RANK];
	logic signed [REL_W-1:0] refl     [RANK];
	logic signed [REL_W-1:0] clmp     [RANK];
	logic [RANK-1:0]         in_ok;
	logic [RANK-1:0]         at_end;
	logic [RANK-1:0]         in_zero;
	logic [RANK-1:0]         out_zero;
	logic                    accept;
	logic                    is_emit;
	logic                    in_region;
	logic                    use_store;

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;
	assign is_emit   = (req_data.req_type == REQ_EMIT);

	// per-axis source coordinate
	always_comb begin
		for (int a = 0; a < RANK; a++) begin
			dimx[a]     = $signed({2'b00, lane(cfg.in_shape, a)});
			rel[a]      = $signed({2'b00, coord_q[a]}) - $signed({2'b00, lane(cfg.pad_begins, a)});
			in_ok[a]    = !rel[a][REL_W-1] && (rel[a] < dimx[a]);
			in_zero[a]  = (lane(cfg.in_shape, a) == '0);
			out_zero[a] = (lane(cfg.out_shape, a) == '0);
			at_end[a]   = ({1'b0, coord_q[a]} + 1'b1) >= {1'b0, lane(cfg.out_shape, a)};
			refl[a]     = rel[a];
			if (cfg.pad_mode == MODE_REFLECT) begin
				if (refl[a][REL_W-1]) begin
					refl[a] = -refl[a];
				end
				if (refl[a] >= dimx[a]) begin
					refl[a] = (dimx[a] <<< 1) - refl[a] - TWO;
				end
			end
			clmp[a] = refl[a];
			if (clmp[a][REL_W-1]) begin
				clmp[a] = '0;
			end
			if (clmp[a] > dimx[a] - ONE) begin
				clmp[a] = dimx[a] - ONE;
			end
		end
	end

	assign in_region = &in_ok;
	assign use_store = in_region
		|| (!(|in_zero) && (cfg.pad_mode == MODE_REFLECT || cfg.pad_mode == MODE_EDGE));

	// row-major step with carry, wraps after the last element
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int a = RANK - 1; a >= 0; a--) begin
			coord_nx[a] = coord_q[a];
			if (carry) begin
				if (at_end[a]) begin
					coord_nx[a] = '0;
				end else begin
					coord_nx[a] = coord_q[a] + 1'b1;
					carry       = 1'b0;
				end
			end
		end
	end

	always_comb begin
		q_data        = '0;
		q_data.op     = !is_emit ? OP_LOAD : (use_store ? OP_FETCH : OP_FILL);
		q_data.is_pad = !in_region;
		q_data.last   = &at_end;
		q_data.addr   = req_data.load_addr;
		q_data.value  = req_data.load_value;
		for (int a = 0; a < RANK; a++) begin
			q_data.idx[a] = clmp[a][DIM_W-1:0];
		end
	end

	// emits against an empty output shape are dropped
	assign q_push = accept && (!is_emit || !(|out_zero));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < RANK; a++) begin
				coord_q[a] <= '0;
			end
		end else if (coord_clr) begin
			for (int a = 0; a < RANK; a++) begin
				coord_q[a] <= '0;
			end
		end else if (accept && is_emit && !(|out_zero)) begin
			for (int a = 0; a < RANK; a++) begin
				coord_q[a] <= coord_nx[a];
			end
		end
	end

endmodule

// ===== design/tpad4_back.sv =====
`timescale 1ns / 1ps

module tpad4_back #(
	parameter int STORE_DEPTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tpad4_pkg::cfg_t   cfg,
	input  tpad4_pkg::qent_t  head,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tpad4_pkg::rsp_t   rsp_data
);
	import tpad4_pkg::*;

	localparam int AW   = $clog2(STORE_DEPTH);
	localparam bit POW2 = (STORE_DEPTH & (STORE_DEPTH - 1)) == 0;
	localparam int AXW  = $clog2(RANK);
	localparam int BW   = $clog2(DIM_W);
	localparam logic [BW-1:0]  BIT_TOP   = BW'(DIM_W - 1);
	localparam logic [AXW-1:0] AXIS_LAST = AXW'(RANK - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_READ
	} state_t;

	state_t                     state_q;
	logic [AXW-1:0]             axis_q;
	logic [BW-1:0]              bit_q;
	logic                       rsp_valid_q;
	logic [AW-1:0]              lin_q;
	logic [AW-1:0]              acc_q;
	op_t                        job_op_q;
	logic                       job_pad_q;
	logic                       job_last_q;
	logic [VALUE_W-1:0]         job_value_q;
	logic [RANK-1:0][DIM_W-1:0] dims_q;
	logic [RANK-1:0][DIM_W-1:0] idx_q;
	rsp_t                       rsp_q;

	logic [DIM_W-1:0]   cur_dim;
	logic [DIM_W-1:0]   cur_idx;
	logic [AW-1:0]      acc_next;
	logic               axis_end;
	logic               mac_fin;
	logic               slot_free;
	logic               rsp_load;
	logic               mem_we;
	logic               mem_re;
	logic [VALUE_W-1:0] mem_rdata;

	assign cur_dim   = dims_q[axis_q];
	assign cur_idx   = idx_q[axis_q];
	assign slot_free = !rsp_valid_q || !rsp_stall;

	// address step: lin = (lin * dim + idx) mod STORE_DEPTH
	generate
		if (POW2) begin : g_pow2
			logic [AW+DIM_W-1:0] mac_prod;
			logic [AW+DIM_W:0]   mac_sum;
			assign mac_prod = lin_q * cur_dim;
			assign mac_sum  = mac_prod + cur_idx;
			assign acc_next = mac_sum[AW-1:0];
			assign axis_end = 1'b1;
		end else begin : g_serial
			// MSB first, one bit of dim and idx per cycle
			localparam logic [AW:0] DEPTH_W = (AW + 1)'(STORE_DEPTH);
			logic [AW:0] dbl;
			logic [AW:0] dbl_r;
			logic [AW:0] add;
			logic [AW:0] add_r;
			assign dbl      = {acc_q, cur_idx[bit_q]};
			assign dbl_r    = (dbl >= DEPTH_W) ? dbl - DEPTH_W : dbl;
			assign add      = dbl_r + (cur_dim[bit_q] ? {1'b0, lin_q} : '0);
			assign add_r    = (add >= DEPTH_W) ? add - DEPTH_W : add;
			assign acc_next = add_r[AW-1:0];
			assign axis_end = (bit_q == '0);
		end
	endgenerate

	assign mac_fin = (state_q == ST_MAC) && axis_end && (axis_q == AXIS_LAST);
	assign mem_we  = mac_fin && (job_op_q == OP_LOAD);
	assign mem_re  = mac_fin && (job_op_q == OP_FETCH);

	always_comb begin
		q_pop = 1'b0;
		if (state_q == ST_IDLE && !q_empty) begin
			q_pop = (head.op != OP_FILL) || slot_free;
		end
	end

	assign rsp_load = (state_q == ST_IDLE && q_pop && head.op == OP_FILL)
		|| (state_q == ST_READ && slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			bit_q       <= BIT_TOP;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						axis_q <= '0;
						bit_q  <= BIT_TOP;
						unique case (head.op)
							OP_LOAD, OP_FETCH: state_q <= ST_MAC;
							OP_FILL: begin
								rsp_q.out_value  <= cfg.pad_constant;
								rsp_q.out_is_pad <= head.is_pad;
								rsp_q.out_last   <= head.last;
							end
							default:           state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MAC: begin
					if (axis_end) begin
						bit_q <= BIT_TOP;
						if (axis_q == AXIS_LAST) begin
							state_q <= (job_op_q == OP_FETCH) ? ST_READ : ST_IDLE;
						end else begin
							axis_q <= axis_q + 1'b1;
						end
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_READ: begin
					if (slot_free) begin
						rsp_q.out_value  <= mem_rdata;
						rsp_q.out_is_pad <= job_pad_q;
						rsp_q.out_last   <= job_last_q;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					lin_q       <= '0;
					acc_q       <= '0;
					job_op_q    <= head.op;
					job_pad_q   <= head.is_pad;
					job_last_q  <= head.last;
					job_value_q <= head.value;
					// a load runs as idx of the last axis with all dims zero
					dims_q      <= '0;
					idx_q       <= '0;
					if (head.op == OP_LOAD) begin
						idx_q[RANK-1] <= DIM_W'(head.addr);
					end else begin
						idx_q <= head.idx;
						for (int a = 0; a < RANK; a++) begin
							dims_q[a] <= lane(cfg.in_shape, a);
						end
					end
				end
			end
			ST_MAC: begin
				if (axis_end) begin
					lin_q <= acc_next;
					acc_q <= '0;
				end else begin
					acc_q <= acc_next;
				end
			end
			default: ;
		endcase
	end

	tpad4_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (acc_next),
		.wdata (job_value_q),
		.re    (mem_re),
		.raddr (acc_next),
		.rdata (mem_rdata)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== design/tensor_pad_4d.sv =====
// Channel  | Direction | Handshake            | Payload
// cfg      | in        | cfg_we               | cfg_idx, cfg_wdata
// req      | in        | req_valid, req_stall | req_data (req_t)
// rsp      | out       | rsp_valid, rsp_stall | rsp_data (rsp_t)
//
// A constant-fill emit goes straight to the output register. A load and a store emit
// run through the address unit (one multiply-add per axis); a store emit then does one
// RAM read. With a STORE_DEPTH that is not a power of two, each axis is bit-serial.
// Reset clears config, coordinates and control; store contents stay undefined.
// req stalls only when the 4-entry queue is full; results wait in an output register.
`timescale 1ns / 1ps
`include "tensor_pad_4d_defines.svh"

module tensor_pad_4d #(
	parameter int STORE_DEPTH = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tpad4_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tpad4_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  tpad4_pkg::req_t                  req_data,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output tpad4_pkg::rsp_t                  rsp_data
);
	import tpad4_pkg::*;

	cfg_t  cfg_q;
	logic  coord_clr;
	logic  q_push;
	qent_t q_data;
	logic  q_full;
	logic  q_pop;
	qent_t q_head;
	logic  q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_IN_SHAPE:     cfg_q.in_shape     <= cfg_wdata;
				REG_OUT_SHAPE:    cfg_q.out_shape    <= cfg_wdata;
				REG_PAD_BEGINS:   cfg_q.pad_begins   <= cfg_wdata;
				REG_PAD_MODE:     cfg_q.pad_mode     <= cfg_wdata[MODE_W-1:0];
				REG_PAD_CONSTANT: cfg_q.pad_constant <= cfg_wdata[VALUE_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign coord_clr = cfg_we && (cfg_idx == REG_OUT_SHAPE);

	tpad4_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.coord_clr (coord_clr),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.q_push    (q_push),
		.q_data    (q_data),
		.q_full    (q_full)
	);

	tpad4_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	tpad4_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	`TPAD4_ASSERT_SAME(a_push_room, q_push, !q_full, "queue push while full")
	`TPAD4_ASSERT_SAME(a_pop_data, q_pop, !q_empty, "queue pop while empty")
	`TPAD4_ASSERT_NEXT(a_fill_out, q_pop && q_head.op == OP_FILL, rsp_valid, "fill lost")

endmodule

// ===== test/tpad4_checker.sv =====
`timescale 1ns / 1ps

package tpad4_tb_pkg;
	import tpad4_pkg::*;

	function automatic int dim_at(input logic [CFG_DATA_W-1:0] v, input int axis);
		return int'(v[(RANK - 1 - axis) * DIM_W +: DIM_W]);
	endfunction

	// where one output element comes from: store address, pad flag, store read or fill
	function automatic void locate(input cfg_t c, input logic [CFG_DATA_W-1:0] crd,
		output bit from_store, output bit is_pad, output logic [ADDR_W-1:0] addr);
		int dim;
		int rel;
		bit in_region;
		bit empty_in;
		logic [63:0] lin;
		in_region = 1'b1;
		empty_in = 1'b0;
		lin = '0;
		for (int a = 0; a < RANK; a++) begin
			dim = dim_at(c.in_shape, a);
			rel = dim_at(crd, a) - dim_at(c.pad_begins, a);
			if (dim == 0) empty_in = 1'b1;
			if (rel < 0 || rel >= dim) in_region = 1'b0;
			if (c.pad_mode == MODE_REFLECT) begin
				if (rel < 0) rel = -rel;
				if (rel >= dim) rel = 2 * dim - rel - 2;
			end
			if (rel < 0) rel = 0;
			if (rel > dim - 1) rel = dim - 1;
			lin = lin * 64'(dim) + 64'(rel);
		end
		from_store = in_region ||
			(!empty_in && (c.pad_mode == MODE_REFLECT || c.pad_mode == MODE_EDGE));
		is_pad = !in_region;
		addr = lin[ADDR_W-1:0];
	endfunction

	// row-major step with carry, wraps to the first position
	function automatic logic [CFG_DATA_W-1:0] next_coord(input cfg_t c,
		input logic [CFG_DATA_W-1:0] crd);
		logic [CFG_DATA_W-1:0] nxt;
		bit carry;
		int v;
		nxt = crd;
		carry = 1'b1;
		for (int a = RANK - 1; a >= 0; a--) begin
			v = dim_at(crd, a);
			if (carry) begin
				if (v + 1 >= dim_at(c.out_shape, a)) begin
					v = 0;
				end else begin
					v = v + 1;
					carry = 1'b0;
				end
			end
			nxt[(RANK - 1 - a) * DIM_W +: DIM_W] = v[DIM_W-1:0];
		end
		return nxt;
	endfunction

endpackage

module tpad4_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tpad4_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tpad4_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             req_valid,
	input  logic                             req_stall,
	input  tpad4_pkg::req_t                  req_data,
	input  logic                             rsp_valid,
	input  logic                             rsp_stall,
	input  tpad4_pkg::rsp_t                  rsp_data,
	output int                               fail_count,
	output int                               pending
);
	import tpad4_pkg::*;
	import tpad4_tb_pkg::*;

	cfg_t                  regs;
	logic [CFG_DATA_W-1:0] crd;
	logic [VALUE_W-1:0]    image [1 << ADDR_W];
	rsp_t                  expected_elems [$];
	int                    n_err = 0;

	always @(posedge clk or negedge arst_n) begin : track
		rsp_t want;
		bit from_store;
		bit is_pad;
		bit last;
		bit out_ok;
		logic [ADDR_W-1:0] addr;
		if (!arst_n) begin
			regs = '0;
			crd = '0;
			expected_elems.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_IN_SHAPE: regs.in_shape = cfg_wdata;
					REG_OUT_SHAPE: begin
						regs.out_shape = cfg_wdata;
						crd = '0;
					end
					REG_PAD_BEGINS: regs.pad_begins = cfg_wdata;
					REG_PAD_MODE: regs.pad_mode = cfg_wdata[MODE_W-1:0];
					REG_PAD_CONSTANT: regs.pad_constant = cfg_wdata[VALUE_W-1:0];
					default: ;
				endcase
			end

			if (rsp_valid && !rsp_stall) begin
				if (expected_elems.size() == 0) begin
					$error("unexpected transfer: out_value %h", rsp_data.out_value);
					n_err++;
				end else begin
					want = expected_elems.pop_front();
					if (rsp_data.out_value !== want.out_value) begin
						$error("out_value: expected %h, got %h", want.out_value,
							rsp_data.out_value);
						n_err++;
					end
					if (rsp_data.out_is_pad !== want.out_is_pad) begin
						$error("out_is_pad: expected %b, got %b", want.out_is_pad,
							rsp_data.out_is_pad);
						n_err++;
					end
					if (rsp_data.out_last !== want.out_last) begin
						$error("out_last: expected %b, got %b", want.out_last,
							rsp_data.out_last);
						n_err++;
					end
				end
			end

			if (req_valid && !req_stall) begin
				if (req_data.req_type == REQ_LOAD) begin
					image[req_data.load_addr] = req_data.load_value;
				end else begin
					out_ok = 1'b1;
					last = 1'b1;
					for (int a = 0; a < RANK; a++) begin
						if (dim_at(regs.out_shape, a) == 0) out_ok = 1'b0;
						if (dim_at(crd, a) + 1 < dim_at(regs.out_shape, a)) last = 1'b0;
					end
					if (out_ok) begin
						locate(regs, crd, from_store, is_pad, addr);
						want.out_value = from_store ? image[addr] : regs.pad_constant;
						want.out_is_pad = is_pad;
						want.out_last = last;
						expected_elems.push_back(want);
						crd = next_coord(regs, crd);
					end
				end
			end
			pending <= expected_elems.size();
		end
		fail_count <= n_err;
	end

endmodule

// ===== test/tb_tensor_pad_4d.sv =====
`timescale 1ns / 1ps

module tb_tensor_pad_4d;
	import tpad4_pkg::*;
	import tpad4_tb_pkg::*;

	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 600;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
	localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req_data;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp_data;

	int fail_count;
	int pending;
	int n_sent = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit written [1 << ADDR_W];

	tensor_pad_4d dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	tpad4_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic send(input req_t item);
		req_valid <= 1'b1;
		req_data <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
		n_sent++;
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic load(input logic [ADDR_W-1:0] addr, input logic [VALUE_W-1:0] value);
		req_t r;
		r.req_type = REQ_LOAD;
		r.load_addr = addr;
		r.load_value = value;
		written[addr] = 1'b1;
		send(r);
	endtask

	task automatic emit();
		req_t r;
		r.req_type = REQ_EMIT;
		r.load_addr = ADDR_W'($urandom);
		r.load_value = $urandom;
		send(r);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	// configure, fill every store entry the emits will read, then emit
	task automatic run_phase(input cfg_t c, input int n_emit, input bit noise,
		input bit squeeze);
		logic [CFG_DATA_W-1:0] crd;
		bit from_store;
		bit is_pad;
		logic [ADDR_W-1:0] addr;
		settle();
		put(REG_IN_SHAPE, c.in_shape);
		put(REG_OUT_SHAPE, c.out_shape);
		put(REG_PAD_BEGINS, c.pad_begins);
		put(REG_PAD_MODE, CFG_DATA_W'(c.pad_mode));
		put(REG_PAD_CONSTANT, CFG_DATA_W'(c.pad_constant));
		put(REG_SPARE, {$urandom, $urandom});
		cfg_we <= 1'b0;
		crd = '0;
		for (int i = 0; i < n_emit; i++) begin
			locate(c, crd, from_store, is_pad, addr);
			if (from_store && !written[addr]) load(addr, $urandom);
			crd = next_coord(c, crd);
		end
		if (squeeze) hold_req = 1'b1;
		for (int i = 0; i < n_emit; i++) begin
			if (noise && $urandom_range(0, 7) == 0) load(ADDR_W'($urandom), $urandom);
			emit();
		end
	endtask

	initial begin : stimulus
		cfg_t c;
		int base;
		int d;
		int pb;
		int pe;
		int o;
		int n_emit;
		longint prod;
		bit squeezed;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req_data = '0;
		squeezed = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset leaves an empty output: emit gives nothing
		emit();
		load(12'hFFF, 32'hFFFF_FFFF);
		load(12'h000, 32'h0000_0000);

		// reflection past the far edge
		c = '0;
		c.in_shape = {16'd1, 16'd1, 16'd1, 16'd2};
		c.out_shape = {16'd1, 16'd1, 16'd1, 16'd8};
		c.pad_begins = {16'd0, 16'd0, 16'd0, 16'd3};
		c.pad_mode = MODE_REFLECT;
		c.pad_constant = 32'h1234_5678;
		run_phase(c, 9, 1'b0, 1'b0);

		// linear read address beyond the store depth
		c.in_shape = {16'd2, 16'd1, 16'd1, 16'hFFFF};
		c.out_shape = {16'd2, 16'd1, 16'd1, 16'd1};
		c.pad_begins = '0;
		c.pad_mode = MODE_CONST;
		run_phase(c, 2, 1'b0, 1'b0);

		// empty input, edge mode still fills
		c.in_shape = {16'd0, 16'd1, 16'd1, 16'd1};
		c.out_shape = {16'd1, 16'd1, 16'd1, 16'd2};
		c.pad_mode = MODE_EDGE;
		c.pad_constant = 32'hFFFF_FFFF;
		run_phase(c, 2, 1'b0, 1'b0);

		// undefined mode
		c.in_shape = {16'd1, 16'd1, 16'd1, 16'd1};
		c.pad_begins = {16'd0, 16'd0, 16'd0, 16'd1};
		c.pad_mode = MODE_SPARE;
		c.pad_constant = 32'h0000_0000;
		run_phase(c, 2, 1'b0, 1'b0);

		// widest pads and output
		c.out_shape = {4{16'hFFFF}};
		c.pad_begins = {4{16'hFFFF}};
		c.pad_mode = MODE_EDGE;
		run_phase(c, 2, 1'b0, 1'b0);

		base = n_sent;
		while (n_sent - base < RANDOM_ITEMS) begin
			c = '0;
			for (int a = 0; a < RANK; a++) begin
				d = (a < 2) ? $urandom_range(1, 2) : $urandom_range(1, 4);
				if ($urandom_range(0, 24) == 0) d = 0;
				pb = $urandom_range(0, (a < 2) ? 1 : 2);
				pe = $urandom_range(0, (a < 2) ? 1 : 2);
				if ($urandom_range(0, 9) == 0) pb = $urandom_range(3, 6);
				o = d + pb + pe;
				if ($urandom_range(0, 39) == 0) o = 0;
				if ($urandom_range(0, 29) == 0) begin
					d = $urandom_range(0, 65535);
					pb = $urandom_range(0, 65535);
				end
				c.in_shape[(RANK - 1 - a) * DIM_W +: DIM_W] = d[DIM_W-1:0];
				c.out_shape[(RANK - 1 - a) * DIM_W +: DIM_W] = o[DIM_W-1:0];
				c.pad_begins[(RANK - 1 - a) * DIM_W +: DIM_W] = pb[DIM_W-1:0];
			end
			c.pad_mode = MODE_W'($urandom_range(0, 3));
			c.pad_constant = $urandom;
			prod = 1;
			for (int a = 0; a < RANK; a++) prod = prod * dim_at(c.out_shape, a);
			n_emit = (prod <= 120) ? int'(prod) + $urandom_range(0, 3) : $urandom_range(20, 80);
			calm = (n_sent - base) > RANDOM_ITEMS * 5 / 6;
			run_phase(c, n_emit, 1'b1, !squeezed && n_emit >= 20);
			if (n_emit >= 20) squeezed = 1'b1;
		end

		settle();
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/tpad4_pkg.sv
design/tpad4_ram.sv
design/tpad4_queue.sv
design/tpad4_front.sv
design/tpad4_back.sv
design/tensor_pad_4d.sv
test/tpad4_checker.sv
test/tb_tensor_pad_4d.sv
